[rtl/core/knob_smoother_deadband_top_assert.svh]
// Assertion macros shared by the knob smoother RTL.
// Both macros expect signals named clk and arst_n in the enclosing module.
`ifndef KNOB_SMOOTHER_DEADBAND_TOP_ASSERT_SVH
`define KNOB_SMOOTHER_DEADBAND_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KDS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/kds_pkg.sv]
package kds_pkg;

	localparam int ADC_BITS_DEF      = 12;
	localparam int FRACTION_BITS_DEF = 8;
	localparam int LANES             = 3;

	localparam int ALPHA_W     = 17;
	localparam int DEADBAND_W  = 20;
	localparam int CFG_DATA_W  = 20;
	localparam int ALPHA_SHIFT = 16;

	localparam logic [ALPHA_W-1:0]    ALPHA_ONE      = 17'h10000;
	localparam logic [ALPHA_W-1:0]    ALPHA_RESET    = 17'd4096;
	localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 20'd2560;

	localparam int LANE_MIX   = 0;
	localparam int LANE_TONE  = 1;
	localparam int LANE_LEVEL = 2;

	typedef enum logic [0:0] {
		REG_ALPHA    = 1'b0,
		REG_DEADBAND = 1'b1
	} reg_index_t;

	// Pipeline control broadcast from the top level to every lane.
	typedef struct packed {
		logic accept;
		logic advance;
		logic primed;
		logic first_s1;
	} kds_ctrl_t;

endpackage

[rtl/core/kds_in_if.sv]
interface kds_in_if #(
	parameter int ADC_BITS = kds_pkg::ADC_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] raw_mix;
	logic [ADC_BITS-1:0] tone_raw;
	logic [ADC_BITS-1:0] raw_level;

	modport source (output valid, output raw_mix, output tone_raw, output raw_level,
		input ready);
	modport sink (input valid, input raw_mix, input tone_raw, input raw_level,
		output ready);
endinterface

[rtl/core/kds_out_if.sv]
interface kds_out_if #(
	parameter int VALUE_W = kds_pkg::ADC_BITS_DEF + kds_pkg::FRACTION_BITS_DEF
);
	logic               valid;
	logic               ready;
	logic               mix_commit;
	logic               tone_commit;
	logic               level_commit;
	logic [VALUE_W-1:0] mix_value;
	logic [VALUE_W-1:0] tone_value;
	logic [VALUE_W-1:0] level_value;
	logic               any_changed;

	modport source (output valid, output mix_commit, output tone_commit,
		output level_commit, output mix_value, output tone_value, output level_value,
		output any_changed, input ready);
	modport sink (input valid, input mix_commit, input tone_commit,
		input level_commit, input mix_value, input tone_value, input level_value,
		input any_changed, output ready);
endinterface

[rtl/core/kds_lane.sv]
// One knob channel: the smoothing recurrence in the first stage and the
// deadband commit decision in the second.
module kds_lane #(
	parameter int ADC_BITS      = kds_pkg::ADC_BITS_DEF,
	parameter int FRACTION_BITS = kds_pkg::FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  kds_pkg::kds_ctrl_t                   ctrl,
	input  logic [kds_pkg::ALPHA_W-1:0]          alpha,
	input  logic [kds_pkg::DEADBAND_W-1:0]       deadband,
	input  logic [ADC_BITS-1:0]                  raw,
	output logic                                 commit,
	output logic [ADC_BITS+FRACTION_BITS-1:0]    committed
);
	localparam int VW    = ADC_BITS + FRACTION_BITS;
	localparam int DW    = VW + 1;
	localparam int PW    = DW + kds_pkg::ALPHA_W + 1;
	localparam int CMP_W = (VW > kds_pkg::DEADBAND_W) ? VW : kds_pkg::DEADBAND_W;

	logic [VW-1:0]        sample;
	logic [VW-1:0]        smoothed_q;
	logic [VW-1:0]        committed_q;
	logic [VW-1:0]        smoothed_next;
	logic signed [DW-1:0] delta;
	logic signed [PW-1:0] product;
	logic signed [PW-1:0] step;
	logic signed [PW-1:0] sum;
	logic [VW-1:0]        distance;

	assign sample = {raw, {FRACTION_BITS{1'b0}}};
	assign delta  = $signed({1'b0, sample}) - $signed({1'b0, smoothed_q});

	// The shift is arithmetic, so the scaled step is floored towards minus
	// infinity. The new value lies between the old one and the sample.
	assign product       = $signed({1'b0, alpha}) * delta;
	assign step          = product >>> kds_pkg::ALPHA_SHIFT;
	assign sum           = PW'($signed({1'b0, smoothed_q})) + step;
	assign smoothed_next = sum[VW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= '0;
		end else if (ctrl.accept) begin
			smoothed_q <= ctrl.primed ? smoothed_next : sample;
		end
	end

	assign distance = (smoothed_q > committed_q) ? (smoothed_q - committed_q)
		: (committed_q - smoothed_q);
	assign commit   = ctrl.first_s1
		|| (CMP_W'(distance) > CMP_W'(deadband));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			committed_q <= '0;
		end else if (ctrl.advance && commit) begin
			committed_q <= smoothed_q;
		end
	end

	assign committed = committed_q;
endmodule

[rtl/core/kds_merge.sv]
// Gathers the lane decisions into the result register and owns the output
// handshake.
module kds_merge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s1,
	input  logic [kds_pkg::LANES-1:0] commit,
	input  logic                      out_ready,
	output logic                      advance,
	output logic                      out_valid,
	output logic [kds_pkg::LANES-1:0] commit_s2,
	output logic                      any_s2
);
	logic out_valid_q;

	assign advance = valid_s1 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			commit_s2 <= commit;
			any_s2    <= |commit;
		end
	end

	assign out_valid = out_valid_q;
endmodule

[rtl/core/knob_smoother_deadband_top.sv]
// Knob smoother with deadband: each item carries one ADC sample for the mix,
// tone and level knobs, and gives exactly one result. The block accepts an
// item every clock cycle while the result is not stalled. The smoothing update
// is registered as the item is taken, and the deadband commit as the item
// advances into the result register, from which the result is presented;
// the rate is set by the per-lane smoothing recurrence, a single multiply
// and add per sample, because each sample builds on the previous
// smoothed value. Values are in ADC counts with FRACTION_BITS fraction bits.
// The first item after reset loads every smoothed value with its sample and
// commits all three knobs. Register 0 (smoothing_alpha) is the gain as a
// fraction of 65536 and saturates at 65536; register 1 (deadband) is the
// commit threshold. Write them only while the block holds no item.
module knob_smoother_deadband_top #(
	parameter int ADC_BITS      = kds_pkg::ADC_BITS_DEF,
	parameter int FRACTION_BITS = kds_pkg::FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	kds_in_if.sink                          knobs,
	kds_out_if.source                       result,
	input  logic                            cfg_wr_en,
	input  kds_pkg::reg_index_t             cfg_index,
	input  logic [kds_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	localparam int VW = ADC_BITS + FRACTION_BITS;

	logic [kds_pkg::ALPHA_W-1:0]    alpha_q;
	logic [kds_pkg::ALPHA_W-1:0]    alpha_eff;
	logic [kds_pkg::DEADBAND_W-1:0] deadband_q;

	logic primed_q;
	logic valid_s1;
	logic first_s1;
	logic accept;
	logic advance;

	kds_pkg::kds_ctrl_t ctrl;

	logic [kds_pkg::LANES-1:0]          commit;
	logic [kds_pkg::LANES-1:0]          commit_s2;
	logic                               any_s2;
	logic [kds_pkg::LANES-1:0][ADC_BITS-1:0] raw;
	logic [kds_pkg::LANES-1:0][VW-1:0]  committed_value;

	// Configuration registers. Only the two listed indexes exist.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q    <= kds_pkg::ALPHA_RESET;
			deadband_q <= kds_pkg::DEADBAND_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				kds_pkg::REG_ALPHA: begin
					alpha_q <= cfg_wdata[kds_pkg::ALPHA_W-1:0];
				end
				kds_pkg::REG_DEADBAND: begin
					deadband_q <= cfg_wdata[kds_pkg::DEADBAND_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Any gain with the top bit set is at or above unity, so it is held at unity.
	assign alpha_eff = alpha_q[kds_pkg::ALPHA_W-1] ? kds_pkg::ALPHA_ONE : alpha_q;

	// The first stage can take a new item whenever it is empty or its item is
	// moving into the result register in the same cycle.
	assign knobs.ready = !valid_s1 || advance;
	assign accept      = knobs.valid && knobs.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			if (accept) begin
				primed_q <= 1'b1;
				valid_s1 <= 1'b1;
				first_s1 <= !primed_q;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign ctrl.accept   = accept;
	assign ctrl.advance  = advance;
	assign ctrl.primed   = primed_q;
	assign ctrl.first_s1 = first_s1;

	assign raw[kds_pkg::LANE_MIX]   = knobs.raw_mix;
	assign raw[kds_pkg::LANE_TONE]  = knobs.tone_raw;
	assign raw[kds_pkg::LANE_LEVEL] = knobs.raw_level;

	// One lane per knob; they share the control and the configuration.
	for (genvar g = 0; g < kds_pkg::LANES; g++) begin : g_lane
		kds_lane #(
			.ADC_BITS      (ADC_BITS),
			.FRACTION_BITS (FRACTION_BITS)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.alpha     (alpha_eff),
			.deadband  (deadband_q),
			.raw       (raw[g]),
			.commit    (commit[g]),
			.committed (committed_value[g])
		);
	end

	kds_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.commit    (commit),
		.out_ready (result.ready),
		.advance   (advance),
		.out_valid (result.valid),
		.commit_s2 (commit_s2),
		.any_s2    (any_s2)
	);

	// The committed values only change as an item enters the result register,
	// so they serve directly as the value fields of the result.
	assign result.mix_commit   = commit_s2[kds_pkg::LANE_MIX];
	assign result.tone_commit  = commit_s2[kds_pkg::LANE_TONE];
	assign result.level_commit = commit_s2[kds_pkg::LANE_LEVEL];
	assign result.mix_value    = committed_value[kds_pkg::LANE_MIX];
	assign result.tone_value   = committed_value[kds_pkg::LANE_TONE];
	assign result.level_value  = committed_value[kds_pkg::LANE_LEVEL];
	assign result.any_changed  = any_s2;

`include "knob_smoother_deadband_top_assert.svh"

	`KDS_ASSERT_NEXT(a_first_item_primes, accept && !primed_q,
		primed_q && valid_s1 && first_s1, "first item did not prime the block")
	`KDS_ASSERT_NOW(a_stall_only_when_full, !knobs.ready,
		valid_s1 && result.valid && !result.ready, "input stalled without a full pipe")
	`KDS_ASSERT_NEXT(a_committed_hold, result.valid && !result.ready,
		$stable(committed_value), "committed values moved under a stalled result")
endmodule
